### design/lpd_pkg.sv
`timescale 1ns / 1ps
package lpd_pkg;

  localparam logic signed [33:0] HALF_PI_Q28  = 34'sd421657428;
  localparam logic signed [33:0] PI_Q28       = 34'sd843314857;
  localparam logic signed [33:0] TWO_PI_Q28   = 34'sd1686629713;
  localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;
  localparam logic [19:0]        G0_Q16       = 20'd642690;
  localparam logic signed [45:0] G_LUNAR_Q20  = 46'sd1698693;
  localparam logic [15:0]        DT_MAX       = 16'd6553;
  localparam logic [16:0]        ONE_Q16      = 17'd65536;
  localparam logic [4:0]         CORDIC_LAST  = 5'd27;
  localparam logic [5:0]         DIV_LAST     = 6'd63;

  typedef enum logic [2:0] {
    CFG_DRY_MASS  = 3'd0,
    CFG_INIT_PROP = 3'd1,
    CFG_MAX_THR   = 3'd2,
    CFG_MIN_THR   = 3'd3,
    CFG_ISP       = 3'd4,
    CFG_INERTIA   = 3'd5,
    CFG_RCS       = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOT_INIT = 2'd1,
    STAT_INVALID  = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    U_THR, U_THRUST, U_BNUM, U_BDEN, U_BDIV, U_BURN, U_MASS,
    U_TQ1, U_TQ2, U_TQ3, U_TQDIV, U_RATE, U_PMUL, U_PITCH, U_CORD,
    U_AXMUL, U_AXNUM, U_AXDIV, U_AX, U_AZMUL, U_AZNUM, U_AZDIV, U_AZ,
    U_VXMUL, U_VX, U_VZMUL, U_VZ, U_XMUL, U_X, U_ZMUL, U_Z
  } uop_t;

  typedef struct packed {
    logic    cap;
    logic    load;
    logic    go;
    uop_t    uop;
    logic    res_we;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic op;
    logic ready;
    logic landed;
    logic dt_ok;
    logic load_ok;
    logic unit_done;
  } dp_stat_t;

  function automatic logic is_div_launch(input uop_t u);
    return u inside {U_BDIV, U_TQDIV, U_AXDIV, U_AZDIV};
  endfunction

  function automatic logic is_launch(input uop_t u);
    return is_div_launch(u) || (u == U_CORD);
  endfunction

  function automatic logic [27:0] atan_q28(input logic [4:0] i);
    case (i)
      5'd0:  return 28'd210828714;
      5'd1:  return 28'd124459457;
      5'd2:  return 28'd65760959;
      5'd3:  return 28'd33381290;
      5'd4:  return 28'd16755422;
      5'd5:  return 28'd8385879;
      5'd6:  return 28'd4193963;
      5'd7:  return 28'd2097109;
      5'd8:  return 28'd1048571;
      5'd9:  return 28'd524287;
      5'd10: return 28'd262144;
      5'd11: return 28'd131072;
      5'd12: return 28'd65536;
      5'd13: return 28'd32768;
      5'd14: return 28'd16384;
      5'd15: return 28'd8192;
      5'd16: return 28'd4096;
      5'd17: return 28'd2048;
      5'd18: return 28'd1024;
      5'd19: return 28'd512;
      5'd20: return 28'd256;
      5'd21: return 28'd128;
      5'd22: return 28'd64;
      5'd23: return 28'd32;
      5'd24: return 28'd16;
      5'd25: return 28'd8;
      5'd26: return 28'd4;
      5'd27: return 28'd2;
      default: return 28'd0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
    if (v > 64'sd549755813887) return 40'sh7fffffffff;
    else if (v < -64'sd549755813888) return 40'sh8000000000;
    else return v[39:0];
  endfunction

  function automatic logic signed [45:0] clamp_acc(input logic signed [63:0] v);
    if (v > 64'sd8796093022208) return 46'sd8796093022208;
    else if (v < -64'sd8796093022208) return -46'sd8796093022208;
    else return v[45:0];
  endfunction

endpackage

### design/lpd_ifs.sv
`timescale 1ns / 1ps
interface lpd_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic        [17:0] throttle_cmd;
  logic signed [17:0] torque_cmd;
  logic        [15:0] time_step;
  logic signed [39:0] gate_altitude;
  logic signed [39:0] gate_velocity_x;
  logic signed [39:0] gate_velocity_z;
  logic signed [31:0] gate_pitch;
  logic signed [31:0] gate_pitch_rate;

  modport source (output valid, op, throttle_cmd, torque_cmd, time_step, gate_altitude,
                  gate_velocity_x, gate_velocity_z, gate_pitch, gate_pitch_rate,
                  input ready);
  modport sink (input valid, op, throttle_cmd, torque_cmd, time_step, gate_altitude,
                gate_velocity_x, gate_velocity_z, gate_pitch, gate_pitch_rate,
                output ready);
endinterface

interface lpd_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [39:0] altitude;
  logic signed [39:0] downrange;
  logic signed [39:0] velocity_x;
  logic signed [39:0] velocity_z;
  logic signed [31:0] pitch;
  logic signed [31:0] pitch_rate;
  logic        [32:0] total_mass;
  logic        [31:0] propellant_left;
  logic               landed;

  modport source (output valid, status, altitude, downrange, velocity_x, velocity_z, pitch,
                  pitch_rate, total_mass, propellant_left, landed,
                  input ready);
  modport sink (input valid, status, altitude, downrange, velocity_x, velocity_z, pitch,
                pitch_rate, total_mass, propellant_left, landed,
                output ready);
endinterface

### design/lpd_div.sv
`timescale 1ns / 1ps
module lpd_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);
  import lpd_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] rem_r;
  logic [63:0] quo_r;
  logic [63:0] den_r;
  logic [64:0] trial;
  logic        fits;

  assign trial = {rem_r, quo_r[63]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring divide, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= 64'(trial - {1'b0, den_r});
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= trial[63:0];
        quo_r <= {quo_r[62:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

### design/lpd_cordic.sv
`timescale 1ns / 1ps
module lpd_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] angle,
  output logic               done,
  output logic signed [23:0] sin_q20,
  output logic signed [23:0] cos_q20
);
  import lpd_pkg::*;

  logic               busy_r;
  logic               fin_r;
  logic               done_r;
  logic [4:0]         i_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic               neg_r;
  logic signed [23:0] sin_r, cos_r;

  logic signed [33:0] a0, z1, z2, z3;
  logic               neg0;
  logic signed [33:0] xs, ys, at, xf, yf;

  // fold the angle into [-pi/2, pi/2]
  always_comb begin
    a0 = {{2{angle[31]}}, angle};
    z1 = (a0 > PI_Q28) ? a0 - TWO_PI_Q28 : a0;
    z2 = (z1 < -PI_Q28) ? z1 + TWO_PI_Q28 : z1;
    neg0 = 1'b1;
    if (z2 > HALF_PI_Q28) z3 = z2 - PI_Q28;
    else if (z2 < -HALF_PI_Q28) z3 = z2 + PI_Q28;
    else begin
      z3 = z2;
      neg0 = 1'b0;
    end
  end

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign at = $signed({6'b0, atan_q28(i_r)});
  assign xf = neg_r ? -x_r : x_r;
  assign yf = neg_r ? -y_r : y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && i_r == CORDIC_LAST) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= CORDIC_K_Q30;
      y_r   <= '0;
      z_r   <= z3;
      neg_r <= neg0;
      i_r   <= '0;
    end else if (busy_r) begin
      if (!z_r[33]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
      i_r <= i_r + 5'd1;
    end
    if (fin_r) begin
      sin_r <= yf[33:10];
      cos_r <= xf[33:10];
    end
  end

  assign done    = done_r;
  assign sin_q20 = sin_r;
  assign cos_q20 = cos_r;
endmodule

### design/lpd_dp.sv
`timescale 1ns / 1ps
module lpd_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  lpd_pkg::dp_cmd_t   cmd,
  output lpd_pkg::dp_stat_t  stat,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_op,
  input  logic        [17:0] in_throttle_cmd,
  input  logic signed [17:0] in_torque_cmd,
  input  logic        [15:0] in_time_step,
  input  logic signed [39:0] in_gate_altitude,
  input  logic signed [39:0] in_gate_velocity_x,
  input  logic signed [39:0] in_gate_velocity_z,
  input  logic signed [31:0] in_gate_pitch,
  input  logic signed [31:0] in_gate_pitch_rate,
  output logic        [1:0]  out_status,
  output logic signed [39:0] out_altitude,
  output logic signed [39:0] out_downrange,
  output logic signed [39:0] out_velocity_x,
  output logic signed [39:0] out_velocity_z,
  output logic signed [31:0] out_pitch,
  output logic signed [31:0] out_pitch_rate,
  output logic        [32:0] out_total_mass,
  output logic        [31:0] out_propellant_left,
  output logic               out_landed
);
  import lpd_pkg::*;

  // captured item
  logic               op_r;
  logic        [17:0] thr_cmd_r;
  logic signed [17:0] tq_cmd_r;
  logic        [15:0] dt_r;
  logic signed [39:0] g_alt_r, g_vx_r, g_vz_r;
  logic signed [31:0] g_pitch_r, g_rate_r;

  // register file and latched copies
  logic [31:0] cfg_dry_r, cfg_prop_r, cfg_thr_r, cfg_inertia_r, cfg_rcs_r;
  logic [16:0] cfg_min_r;
  logic [23:0] cfg_isp_r;
  logic [31:0] lat_dry_r, lat_thr_r, lat_inertia_r, lat_rcs_r;
  logic [16:0] lat_min_r;
  logic [23:0] lat_isp_r;

  // vehicle state
  logic signed [39:0] alt_r, range_r, vel_x_r, vel_z_r;
  logic signed [31:0] pitch_r, rate_r;
  logic        [31:0] prop_r;
  logic               landed_r, ready_r;

  // working registers
  logic        [16:0] thr_r;
  logic signed [17:0] tqc_r;
  logic        [31:0] thrust_r;
  logic        [32:0] mass_r;
  logic signed [63:0] prod_r;
  logic        [63:0] dnum_r, dden_r;
  logic               dneg_r;
  logic signed [45:0] acc_x_r, acc_z_r;

  // result register
  logic        [1:0]  res_status_r;
  logic signed [39:0] res_alt_r, res_range_r, res_vx_r, res_vz_r;
  logic signed [31:0] res_pitch_r, res_rate_r;
  logic        [32:0] res_mass_r;
  logic        [31:0] res_prop_r;
  logic               res_landed_r;

  logic               div_start, div_done, cor_start, cor_done;
  logic        [63:0] div_q;
  logic signed [23:0] sin_w, cos_w;

  logic signed [16:0] dt_s;
  logic signed [32:0] pabs;
  logic               load_ok, dt_ok;
  logic        [17:0] thr_lo;
  logic signed [17:0] tq_clamp;
  logic        [48:0] m_thrust;
  logic        [47:0] m_bnum;
  logic        [43:0] m_bden;
  logic signed [50:0] m_tq1;
  logic signed [67:0] m_tq2;
  logic signed [48:0] m_pitch;
  logic signed [23:0] trig_sel;
  logic signed [56:0] m_acc;
  logic signed [45:0] acc_sel;
  logic signed [62:0] m_vel;
  logic signed [39:0] vel_sel;
  logic signed [56:0] m_pos;
  logic        [63:0] prod_abs;
  logic signed [63:0] q_s;
  logic        [31:0] burn;
  logic signed [39:0] alt_new;

  assign dt_s = $signed({1'b0, dt_r});
  assign pabs = g_pitch_r[31] ? -{g_pitch_r[31], g_pitch_r} : {g_pitch_r[31], g_pitch_r};

  assign load_ok = (cfg_min_r <= ONE_Q16) && (cfg_dry_r != '0) && (cfg_prop_r != '0) &&
                   (cfg_thr_r != '0) && (cfg_min_r != '0) && (cfg_isp_r != '0) &&
                   (cfg_inertia_r != '0) && (cfg_rcs_r != '0) &&
                   !g_alt_r[39] && (g_alt_r != '0) && (pabs <= HALF_PI_Q28[32:0]);
  assign dt_ok = (dt_r != '0) && (dt_r <= DT_MAX);

  assign thr_lo   = (thr_cmd_r < {1'b0, lat_min_r}) ? {1'b0, lat_min_r} : thr_cmd_r;
  assign tq_clamp = (tq_cmd_r > 18'sd65536) ? 18'sd65536 :
                    ((tq_cmd_r < -18'sd65536) ? -18'sd65536 : tq_cmd_r);

  assign m_thrust = thr_r * lat_thr_r;
  assign m_bnum   = thrust_r * dt_r;
  assign m_bden   = lat_isp_r * G0_Q16;
  assign m_tq1    = tqc_r * $signed({1'b0, lat_rcs_r});
  assign m_tq2    = $signed(prod_r[50:0]) * dt_s;
  assign m_pitch  = rate_r * dt_s;
  assign trig_sel = (cmd.uop == U_AXMUL) ? sin_w : cos_w;
  assign m_acc    = $signed({1'b0, thrust_r}) * trig_sel;
  assign acc_sel  = (cmd.uop == U_VXMUL) ? acc_x_r : acc_z_r;
  assign m_vel    = acc_sel * dt_s;
  assign vel_sel  = (cmd.uop == U_XMUL) ? vel_x_r : vel_z_r;
  assign m_pos    = vel_sel * dt_s;

  assign prod_abs = prod_r[63] ? (~prod_r + 64'd1) : prod_r;
  assign q_s      = dneg_r ? -$signed(div_q) : $signed(div_q);
  assign burn     = (div_q > {32'b0, prop_r}) ? prop_r : div_q[31:0];
  assign alt_new  = sat40($signed({{24{alt_r[39]}}, alt_r}) + (prod_r >>> 16));

  assign div_start = cmd.go && is_div_launch(cmd.uop);
  assign cor_start = cmd.go && (cmd.uop == U_CORD);

  lpd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (dnum_r),
    .den   (dden_r),
    .done  (div_done),
    .quo   (div_q)
  );

  lpd_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .angle   (pitch_r),
    .done    (cor_done),
    .sin_q20 (sin_w),
    .cos_q20 (cos_w)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r      <= in_op;
      thr_cmd_r <= in_throttle_cmd;
      tq_cmd_r  <= in_torque_cmd;
      dt_r      <= in_time_step;
      g_alt_r   <= in_gate_altitude;
      g_vx_r    <= in_gate_velocity_x;
      g_vz_r    <= in_gate_velocity_z;
      g_pitch_r <= in_gate_pitch;
      g_rate_r  <= in_gate_pitch_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_dry_r     <= 32'd256000;
      cfg_prop_r    <= 32'd256000;
      cfg_thr_r     <= 32'd2560000;
      cfg_min_r     <= 17'd6554;
      cfg_isp_r     <= 24'd76800;
      cfg_inertia_r <= 32'd256000;
      cfg_rcs_r     <= 32'd25600;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DRY_MASS:  cfg_dry_r     <= cfg_data;
        CFG_INIT_PROP: cfg_prop_r    <= cfg_data;
        CFG_MAX_THR:   cfg_thr_r     <= cfg_data;
        CFG_MIN_THR:   cfg_min_r     <= cfg_data[16:0];
        CFG_ISP:       cfg_isp_r     <= cfg_data[23:0];
        CFG_INERTIA:   cfg_inertia_r <= cfg_data;
        CFG_RCS:       cfg_rcs_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_dry_r     <= '0;
      lat_thr_r     <= '0;
      lat_min_r     <= '0;
      lat_isp_r     <= '0;
      lat_inertia_r <= '0;
      lat_rcs_r     <= '0;
      alt_r         <= '0;
      range_r       <= '0;
      vel_x_r       <= '0;
      vel_z_r       <= '0;
      pitch_r       <= '0;
      rate_r        <= '0;
      prop_r        <= '0;
      landed_r      <= 1'b0;
      ready_r       <= 1'b0;
    end else if (cmd.load) begin
      if (load_ok) begin
        lat_dry_r     <= cfg_dry_r;
        lat_thr_r     <= cfg_thr_r;
        lat_min_r     <= cfg_min_r;
        lat_isp_r     <= cfg_isp_r;
        lat_inertia_r <= cfg_inertia_r;
        lat_rcs_r     <= cfg_rcs_r;
        prop_r        <= cfg_prop_r;
        alt_r         <= g_alt_r;
        range_r       <= '0;
        vel_x_r       <= g_vx_r;
        vel_z_r       <= g_vz_r;
        pitch_r       <= g_pitch_r;
        rate_r        <= g_rate_r;
        landed_r      <= 1'b0;
        ready_r       <= 1'b1;
      end else begin
        ready_r <= 1'b0;
      end
    end else if (cmd.go) begin
      case (cmd.uop)
        U_BURN:  prop_r  <= prop_r - burn;
        U_RATE:  rate_r  <= sat32({{32{rate_r[31]}}, rate_r} + q_s);
        U_PITCH: pitch_r <= sat32($signed({{32{pitch_r[31]}}, pitch_r}) + (prod_r >>> 16));
        U_VX:    vel_x_r <= sat40($signed({{24{vel_x_r[39]}}, vel_x_r}) + (prod_r >>> 20));
        U_VZ:    vel_z_r <= sat40($signed({{24{vel_z_r[39]}}, vel_z_r}) + (prod_r >>> 20));
        U_X:     range_r <= sat40($signed({{24{range_r[39]}}, range_r}) + (prod_r >>> 16));
        U_Z: begin
          // touchdown: clamp to the surface and latch
          if (alt_new[39] || alt_new == '0) begin
            alt_r    <= '0;
            landed_r <= 1'b1;
          end else begin
            alt_r <= alt_new;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      case (cmd.uop)
        U_THR: begin
          if (thr_cmd_r == '0 || prop_r == '0) thr_r <= '0;
          else if (thr_lo > {1'b0, ONE_Q16}) thr_r <= ONE_Q16;
          else thr_r <= thr_lo[16:0];
          tqc_r <= tq_clamp;
        end
        U_THRUST: thrust_r <= m_thrust[47:16];
        U_BNUM: begin
          dnum_r <= {8'b0, m_bnum, 8'b0};
          dneg_r <= 1'b0;
        end
        U_BDEN:  dden_r <= {20'b0, m_bden};
        U_MASS:  mass_r <= {1'b0, lat_dry_r} + {1'b0, prop_r};
        U_TQ1:   prod_r <= {{13{m_tq1[50]}}, m_tq1};
        U_TQ2:   prod_r <= m_tq2[63:0];
        U_TQ3: begin
          dnum_r <= prod_abs;
          dneg_r <= prod_r[63];
          dden_r <= {28'b0, lat_inertia_r, 4'b0};
        end
        U_PMUL:  prod_r <= {{15{m_pitch[48]}}, m_pitch};
        U_AXMUL, U_AZMUL: prod_r <= {{7{m_acc[56]}}, m_acc};
        U_AXNUM, U_AZNUM: begin
          dnum_r <= prod_abs;
          dneg_r <= prod_r[63];
          dden_r <= {31'b0, mass_r};
        end
        U_AX:    acc_x_r <= clamp_acc(q_s);
        U_AZ:    acc_z_r <= clamp_acc(q_s) - G_LUNAR_Q20;
        U_VXMUL, U_VZMUL: prod_r <= {m_vel[62], m_vel};
        U_XMUL, U_ZMUL:   prod_r <= {{7{m_pos[56]}}, m_pos};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_we) begin
      res_status_r <= cmd.status;
      res_alt_r    <= alt_r;
      res_range_r  <= range_r;
      res_vx_r     <= vel_x_r;
      res_vz_r     <= vel_z_r;
      res_pitch_r  <= pitch_r;
      res_rate_r   <= rate_r;
      res_mass_r   <= {1'b0, lat_dry_r} + {1'b0, prop_r};
      res_prop_r   <= prop_r;
      res_landed_r <= landed_r;
    end
  end

  assign stat.op        = op_r;
  assign stat.ready     = ready_r;
  assign stat.landed    = landed_r;
  assign stat.dt_ok     = dt_ok;
  assign stat.load_ok   = load_ok;
  assign stat.unit_done = div_done | cor_done;

  assign out_status          = res_status_r;
  assign out_altitude        = res_alt_r;
  assign out_downrange       = res_range_r;
  assign out_velocity_x      = res_vx_r;
  assign out_velocity_z      = res_vz_r;
  assign out_pitch           = res_pitch_r;
  assign out_pitch_rate      = res_rate_r;
  assign out_total_mass      = res_mass_r;
  assign out_propellant_left = res_prop_r;
  assign out_landed          = res_landed_r;
endmodule

### design/lpd_ctrl.sv
`timescale 1ns / 1ps
module lpd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lpd_pkg::dp_stat_t stat,
  output lpd_pkg::dp_cmd_t  cmd
);
  import lpd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_EXEC   = 5'b00100,
    ST_WAIT   = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  state_t  state_r, state_nxt;
  uop_t    uop_r, uop_nxt;
  status_t status_r, status_nxt;
  logic    out_valid_r;
  logic    res_we;

  assign res_we = (state_r == ST_RESULT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt  = state_r;
    uop_nxt    = uop_r;
    status_nxt = status_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = ST_RESULT;
        if (!stat.op) begin
          status_nxt = stat.load_ok ? STAT_OK : STAT_INVALID;
        end else if (!stat.ready) begin
          status_nxt = STAT_NOT_INIT;
        end else if (!stat.dt_ok) begin
          status_nxt = STAT_INVALID;
        end else begin
          status_nxt = STAT_OK;
          // landed vehicle: report state as is
          if (!stat.landed) begin
            uop_nxt   = U_THR;
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (is_launch(uop_r)) state_nxt = ST_WAIT;
        else if (uop_r == U_Z) state_nxt = ST_RESULT;
        else uop_nxt = uop_t'(uop_r + 5'd1);
      end
      ST_WAIT: begin
        if (stat.unit_done) begin
          uop_nxt   = uop_t'(uop_r + 5'd1);
          state_nxt = ST_EXEC;
        end
      end
      ST_RESULT: begin
        if (res_we) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      uop_r       <= U_THR;
      status_r    <= STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      uop_r    <= uop_nxt;
      status_r <= status_nxt;
      if (res_we) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  assign cmd.cap    = (state_r == ST_IDLE) && in_valid;
  assign cmd.load   = (state_r == ST_CHECK) && !stat.op;
  assign cmd.go     = (state_r == ST_EXEC);
  assign cmd.uop    = uop_r;
  assign cmd.res_we = res_we;
  assign cmd.status = status_r;
endmodule

### design/lander_planar_dynamics_step_top.sv
`timescale 1ns / 1ps
// Planar lander dynamics, one item in and one result beat out per item.
// in_ch carries a load (op 0) or a time step (op 1); out_ch returns the
// status and the full vehicle state after that item. cfg_we/cfg_index/
// cfg_data write the vehicle registers; a load latches them.
// One item is in flight at a time. A load, a rejected step or a step after
// touchdown goes from the check state straight to the result state, and its
// result beat is registered from there. A full step runs 31 datapath
// micro-ops before its result state, four of them divisions on the shared
// radix-2 divider (burn, torque, two accelerations) and one a 28-step
// CORDIC for sin/cos of the new pitch.
// in_ch.ready is high while the controller is idle, also while the previous
// result still waits in the output register; a new result only overwrites
// that register once it has been taken, so a stalled receiver holds the
// block at its result stage without losing a beat.
// Synchronous reset clears the vehicle state, marks it not initialized and
// restores the register defaults; no result is pending after reset.
module lander_planar_dynamics_step_top (
  input  logic        clk,
  input  logic        rst_n,
  lpd_in_if.sink      in_ch,
  lpd_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import lpd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lpd_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_op               (in_ch.op),
    .in_throttle_cmd     (in_ch.throttle_cmd),
    .in_torque_cmd       (in_ch.torque_cmd),
    .in_time_step        (in_ch.time_step),
    .in_gate_altitude    (in_ch.gate_altitude),
    .in_gate_velocity_x  (in_ch.gate_velocity_x),
    .in_gate_velocity_z  (in_ch.gate_velocity_z),
    .in_gate_pitch       (in_ch.gate_pitch),
    .in_gate_pitch_rate  (in_ch.gate_pitch_rate),
    .out_status          (out_ch.status),
    .out_altitude        (out_ch.altitude),
    .out_downrange       (out_ch.downrange),
    .out_velocity_x      (out_ch.velocity_x),
    .out_velocity_z      (out_ch.velocity_z),
    .out_pitch           (out_ch.pitch),
    .out_pitch_rate      (out_ch.pitch_rate),
    .out_total_mass      (out_ch.total_mass),
    .out_propellant_left (out_ch.propellant_left),
    .out_landed          (out_ch.landed)
  );
endmodule

### verif/tb_lander_planar_dynamics_step_top.sv
`timescale 1ns / 1ps
module tb_lander_planar_dynamics_step_top;
  import lpd_pkg::*;

  localparam int          WATCHDOG_LIMIT = 30000;
  localparam int          MAX_PRINTS     = 40;
  localparam logic [2:0]  CFG_NONE       = 3'd7;
  localparam longint      Q_HALF_PI      = 64'sd421657428;
  localparam longint      Q_PI           = 64'sd843314857;
  localparam longint      Q_TWO_PI       = 64'sd1686629713;
  localparam longint      Q_CORDIC_K     = 64'sd652032874;
  localparam longint      Q_G0           = 64'sd642690;
  localparam longint      Q_G_MOON       = 64'sd1698693;
  localparam longint      Q_ONE          = 64'sd65536;
  localparam longint      Q_DT_MAX       = 64'sd6553;
  localparam longint      Q_ACC_LIM      = 64'sd8796093022208;
  localparam logic [0:0]  OP_LOAD        = 1'b0;
  localparam logic [0:0]  OP_STEP        = 1'b1;

  typedef struct {
    logic               op;
    logic        [17:0] throttle;
    logic signed [17:0] torque;
    logic        [15:0] dt;
    logic signed [39:0] alt;
    logic signed [39:0] vx;
    logic signed [39:0] vz;
    logic signed [31:0] pitch;
    logic signed [31:0] rate;
  } lander_cmd_t;

  typedef struct {
    status_t            status;
    logic signed [39:0] alt;
    logic signed [39:0] range;
    logic signed [39:0] vx;
    logic signed [39:0] vz;
    logic signed [31:0] pitch;
    logic signed [31:0] rate;
    logic        [32:0] mass;
    logic        [31:0] prop;
    logic               landed;
  } vehicle_state_t;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  lpd_in_if  in_ch ();
  lpd_out_if out_ch ();

  lander_planar_dynamics_step_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // vehicle model state
  longint unsigned reg_shadow [7];
  longint unsigned reg_latched [7];
  longint          m_alt, m_range, m_vx, m_vz, m_pitch, m_rate;
  longint unsigned m_prop;
  bit              m_landed, m_ready;
  longint          atan_tbl [28] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
    2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
  int              reg_width [7] = '{32, 32, 32, 17, 24, 32, 32};

  vehicle_state_t  pending_q [$];
  int              errors;
  int              prints;
  int              sent_loads, sent_steps, beats_checked, touchdowns;
  int              send_idle_pct, recv_stall_pct;
  int              hold_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint sat_w(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic longint div_trunc(longint num, longint unsigned den);
    longint unsigned mag;
    longint          q;
    mag = num < 0 ? longint'(0) - num : num;
    q   = longint'(mag / den);
    return num < 0 ? -q : q;
  endfunction

  function automatic longint clamp_accel(longint a);
    return a > Q_ACC_LIM ? Q_ACC_LIM : (a < -Q_ACC_LIM ? -Q_ACC_LIM : a);
  endfunction

  function automatic void pitch_sincos(input longint ang, output longint s,
                                       output longint c);
    longint x, y, z, t;
    bit     flip;
    x = Q_CORDIC_K;
    y = 0;
    z = ang;
    flip = 0;
    if (z > Q_PI) z -= Q_TWO_PI;
    if (z < -Q_PI) z += Q_TWO_PI;
    if (z > Q_HALF_PI) begin
      z -= Q_PI;
      flip = 1;
    end else if (z < -Q_HALF_PI) begin
      z += Q_PI;
      flip = 1;
    end
    for (int i = 0; i < 28; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_tbl[i];
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_tbl[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y >>> 10;
    c = x >>> 10;
  endfunction

  function automatic status_t apply_load(lander_cmd_t c);
    longint a, p;
    bit     ok;
    a  = c.alt;
    p  = c.pitch;
    ok = reg_shadow[CFG_MIN_THR] <= Q_ONE;
    for (int i = 0; i < 7; i++)
      if (reg_shadow[i] == 0) ok = 0;
    if (a <= 0 || (p < 0 ? -p : p) > Q_HALF_PI) ok = 0;
    if (!ok) begin
      m_ready = 0;
      return STAT_INVALID;
    end
    reg_latched = reg_shadow;
    m_prop   = reg_latched[CFG_INIT_PROP];
    m_alt    = a;
    m_range  = 0;
    m_vx     = c.vx;
    m_vz     = c.vz;
    m_pitch  = p;
    m_rate   = c.rate;
    m_landed = 0;
    m_ready  = 1;
    return STAT_OK;
  endfunction

  function automatic status_t apply_step(lander_cmd_t c);
    longint unsigned thr, thrust, burn, mass, dt;
    longint          tq, s, co, ax, az;
    thr = c.throttle;
    dt  = c.dt;
    tq  = c.torque;
    if (!m_ready) return STAT_NOT_INIT;
    if (dt == 0 || dt > Q_DT_MAX) return STAT_INVALID;
    if (m_landed) return STAT_OK;
    if (thr == 0 || m_prop == 0) thr = 0;
    else begin
      if (thr < reg_latched[CFG_MIN_THR]) thr = reg_latched[CFG_MIN_THR];
      if (thr > Q_ONE) thr = Q_ONE;
    end
    thrust = (thr * reg_latched[CFG_MAX_THR]) >> 16;
    burn   = ((thrust * dt) << 8) / (reg_latched[CFG_ISP] * Q_G0);
    if (burn > m_prop) burn = m_prop;
    m_prop -= burn;
    mass = reg_latched[CFG_DRY_MASS] + m_prop;
    if (tq > Q_ONE) tq = Q_ONE;
    if (tq < -Q_ONE) tq = -Q_ONE;
    m_rate = sat_w(m_rate + div_trunc(tq * longint'(reg_latched[CFG_RCS]) * longint'(dt),
                                      reg_latched[CFG_INERTIA] << 4), 32);
    m_pitch = sat_w(m_pitch + ((m_rate * longint'(dt)) >>> 16), 32);
    pitch_sincos(m_pitch, s, co);
    ax = clamp_accel(div_trunc(longint'(thrust) * s, mass));
    az = clamp_accel(div_trunc(longint'(thrust) * co, mass)) - Q_G_MOON;
    m_vx    = sat_w(m_vx + ((ax * longint'(dt)) >>> 20), 40);
    m_vz    = sat_w(m_vz + ((az * longint'(dt)) >>> 20), 40);
    m_range = sat_w(m_range + ((m_vx * longint'(dt)) >>> 16), 40);
    m_alt   = sat_w(m_alt + ((m_vz * longint'(dt)) >>> 16), 40);
    if (m_alt <= 0) begin
      m_alt    = 0;
      m_landed = 1;
      touchdowns++;
    end
    return STAT_OK;
  endfunction

  function automatic void predict_item(lander_cmd_t c);
    vehicle_state_t e;
    e.status = (c.op == OP_STEP) ? apply_step(c) : apply_load(c);
    e.alt    = 40'(m_alt);
    e.range  = 40'(m_range);
    e.vx     = 40'(m_vx);
    e.vz     = 40'(m_vz);
    e.pitch  = 32'(m_pitch);
    e.rate   = 32'(m_rate);
    e.mass   = 33'(reg_latched[CFG_DRY_MASS] + m_prop);
    e.prop   = 32'(m_prop);
    e.landed = m_landed;
    pending_q.push_back(e);
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (prints < MAX_PRINTS) begin
      prints++;
      $display("MISMATCH at %0t: %s", $time, msg);
    end
  endtask

  task automatic check_field(string nm, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", nm, got, want));
  endtask

  // result side: check beats, then pick ready for the next edge
  always @(posedge clk) begin
    vehicle_state_t e;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_q.size() == 0) report_mismatch("result beat with nothing pending");
        else begin
          e = pending_q.pop_front();
          beats_checked++;
          check_field("status", out_ch.status, e.status);
          check_field("altitude", out_ch.altitude, e.alt);
          check_field("downrange", out_ch.downrange, e.range);
          check_field("velocity_x", out_ch.velocity_x, e.vx);
          check_field("velocity_z", out_ch.velocity_z, e.vz);
          check_field("pitch", out_ch.pitch, e.pitch);
          check_field("pitch_rate", out_ch.pitch_rate, e.rate);
          check_field("total_mass", out_ch.total_mass, e.mass);
          check_field("propellant_left", out_ch.propellant_left, e.prop);
          check_field("landed", out_ch.landed, e.landed);
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any beat
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results pending", pending_q.size());
        $display("tb_lander_planar_dynamics_step_top failed");
        $finish;
      end
    end
  end

  task automatic send_item(lander_cmd_t c);
    int gap;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.op              <= c.op;
    in_ch.throttle_cmd    <= c.throttle;
    in_ch.torque_cmd      <= c.torque;
    in_ch.time_step       <= c.dt;
    in_ch.gate_altitude   <= c.alt;
    in_ch.gate_velocity_x <= c.vx;
    in_ch.gate_velocity_z <= c.vz;
    in_ch.gate_pitch      <= c.pitch;
    in_ch.gate_pitch_rate <= c.rate;
    do @(posedge clk); while (!in_ch.ready);
    if (c.op == OP_STEP) sent_steps++;
    else sent_loads++;
    predict_item(c);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(logic [2:0] idx [], logic [31:0] val []);
    for (int i = 0; i < idx.size(); i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      if (idx[i] < 7)
        reg_shadow[idx[i]] = val[i] & ((64'd1 << reg_width[idx[i]]) - 1);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic set_vehicle(logic [31:0] dry, logic [31:0] prop, logic [31:0] thr,
                             logic [31:0] min_thr, logic [31:0] isp, logic [31:0] inertia,
                             logic [31:0] rcs);
    wait_idle();
    write_regs('{CFG_DRY_MASS, CFG_INIT_PROP, CFG_MAX_THR, CFG_MIN_THR, CFG_ISP,
                 CFG_INERTIA, CFG_RCS},
               '{dry, prop, thr, min_thr, isp, inertia, rcs});
  endtask

  function automatic lander_cmd_t load_cmd(longint alt, longint vx, longint vz,
                                           longint pitch, longint rate);
    lander_cmd_t c;
    c = '{default: '0};
    c.op = OP_LOAD; c.alt = 40'(alt); c.vx = 40'(vx); c.vz = 40'(vz);
    c.pitch = 32'(pitch); c.rate = 32'(rate);
    c.throttle = 18'($urandom); c.torque = 18'($urandom); c.dt = 16'($urandom);
    return c;
  endfunction

  function automatic lander_cmd_t step_cmd(longint thr, longint tq, longint dt);
    lander_cmd_t c;
    c.op = OP_STEP; c.throttle = 18'(thr); c.torque = 18'(tq); c.dt = 16'(dt);
    c.alt = 40'({$urandom, $urandom}); c.vx = 40'({$urandom, $urandom});
    c.vz = 40'({$urandom, $urandom}); c.pitch = $urandom; c.rate = $urandom;
    return c;
  endfunction

  function automatic lander_cmd_t noise_cmd();
    lander_cmd_t c;
    c = step_cmd($urandom, $urandom, $urandom_range(0, 65535));
    c.op = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic lander_cmd_t gate_cmd();
    return load_cmd($urandom_range(1, 32'h0400_0000),
                    $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000,
                    -$signed($urandom_range(0, 32'h0020_0000)),
                    $signed($urandom_range(0, 2 * 421657428)) - 421657428,
                    $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
  endfunction

  task automatic test_before_load();
    send_item(step_cmd(65536, 0, 1000));
    send_item(step_cmd(0, 0, 0));
  endtask

  task automatic test_load_checks();
    send_item(load_cmd(0, 0, 0, 0, 0));
    send_item(load_cmd(-1, 0, 0, 0, 0));
    send_item(load_cmd(40'sh80_0000_0000, 0, 0, 0, 0));
    send_item(load_cmd(65536, 0, 0, Q_HALF_PI + 1, 0));
    send_item(load_cmd(65536, 0, 0, -Q_HALF_PI - 1, 0));
    send_item(step_cmd(65536, 0, 100));
    send_item(load_cmd(65536, 0, 0, -Q_HALF_PI, 0));
    send_item(load_cmd(40'sh7f_ffff_ffff, 40'sh7f_ffff_ffff, 40'sh80_0000_0000,
                       Q_HALF_PI, 32'sh7fff_ffff));
  endtask

  task automatic test_step_cases();
    send_item(load_cmd(100 * 65536, 0, -65536, 0, 0));
    send_item(step_cmd(65536, 0, 0));
    send_item(step_cmd(65536, 0, 6554));
    send_item(step_cmd(65536, 0, 65535));
    send_item(step_cmd(0, 131071, 6553));
    send_item(step_cmd(1, -131072, 1));
    send_item(step_cmd(262143, 65536, 6553));
    send_item(step_cmd(100, -65536, 3000));
    send_item(load_cmd(65536, 0, -10 * 65536, 0, 0));
    send_item(step_cmd(0, 0, 6553));
    send_item(step_cmd(0, 0, 6553));
    send_item(step_cmd(65536, 0, 6553));
    // saturate pitch rate and altitude
    send_item(load_cmd(40'sh7f_ffff_ffff, 40'sh7f_ffff_0000, 40'sh7f_ffff_0000,
                       Q_HALF_PI, 32'sh7fff_0000));
    send_item(step_cmd(65536, 131071, 6553));
    send_item(step_cmd(65536, 131071, 6553));
  endtask

  task automatic test_register_cases();
    // a write after a load waits for the next load
    set_vehicle(1, 1, 32'hffff_ffff, 1, 1, 1, 32'hffff_ffff);
    send_item(step_cmd(65536, 65536, 6553));
    send_item(load_cmd(1000 * 65536, 65536, 0, 1000, 0));
    send_item(step_cmd(65536, 65536, 6553));
    send_item(step_cmd(2, -65536, 6553));
    set_vehicle(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 65536, 32'h00ff_ffff,
                32'hffff_ffff, 32'hffff_ffff);
    send_item(load_cmd(1000 * 65536, 0, 0, 0, 0));
    send_item(step_cmd(1, 65536, 6553));
    wait_idle();
    // rejected setups: min throttle above one, a zero register
    write_regs('{CFG_MIN_THR}, '{32'h0001_ffff});
    send_item(load_cmd(65536, 0, 0, 0, 0));
    wait_idle();
    write_regs('{CFG_MIN_THR, CFG_ISP, CFG_NONE}, '{32'd65537, 32'd0, 32'hffff_ffff});
    send_item(load_cmd(65536, 0, 0, 0, 0));
    wait_idle();
    write_regs('{CFG_MIN_THR, CFG_ISP}, '{32'd6554, 32'd76800});
    set_vehicle(256000, 256000, 2560000, 6554, 76800, 256000, 25600);
  endtask

  task automatic test_stall_fill();
    wait_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(load_cmd(500 * 65536, 0, -65536, 0, 0));
    @(negedge clk) hold_left = 2000;
    for (int i = 0; i < 6; i++) send_item(step_cmd($urandom_range(0, 70000), 0, 6553));
  endtask

  task automatic set_idle_phase(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
      default: begin send_idle_pct = 20; recv_stall_pct = 20; end
    endcase
  endtask

  task automatic test_random_flights(int n_items);
    int sent, run_left, roll;
    sent = 0;
    run_left = 0;
    while (sent < n_items) begin
      if (sent % 200 == 0) begin
        set_idle_phase(sent / 200);
        if (sent % 400 == 0 && sent > 0)
          set_vehicle($urandom_range(32'h1_0000, 32'h200_0000),
                      $urandom_range(1, 32'h200_0000),
                      $urandom_range(1, 32'h1000_0000), $urandom_range(1, 65536),
                      $urandom_range(1, 32'h10_0000), $urandom_range(1, 32'h100_0000),
                      $urandom_range(1, 32'h10_0000));
      end
      roll = $urandom_range(99);
      if (roll < 8) send_item(noise_cmd());
      else if (run_left == 0 || (m_landed && roll < 30)) begin
        send_item(gate_cmd());
        run_left = $urandom_range(5, 60);
      end else begin
        send_item(step_cmd($urandom_range(0, 80000),
                           $signed($urandom_range(0, 150000)) - 75000,
                           $urandom_range(1, 6553)));
        run_left--;
      end
      sent++;
    end
  endtask

  initial begin
    int drain;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_LOAD;
    in_ch.throttle_cmd = '0;
    in_ch.torque_cmd = '0;
    in_ch.time_step = '0;
    in_ch.gate_altitude = '0;
    in_ch.gate_velocity_x = '0;
    in_ch.gate_velocity_z = '0;
    in_ch.gate_pitch = '0;
    in_ch.gate_pitch_rate = '0;
    out_ch.ready = 1'b0;
    errors = 0; prints = 0; hold_left = 0;
    sent_loads = 0; sent_steps = 0; beats_checked = 0; touchdowns = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    reg_shadow  = '{256000, 256000, 2560000, 6554, 76800, 256000, 25600};
    reg_latched = '{default: 0};
    m_alt = 0; m_range = 0; m_vx = 0; m_vz = 0; m_pitch = 0; m_rate = 0;
    m_prop = 0; m_landed = 0; m_ready = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_load();
    test_load_checks();
    test_step_cases();
    test_register_cases();
    test_stall_fill();
    test_random_flights(1550);

    wait_idle();
    drain = 0;
    while (drain < 400) begin
      @(posedge clk);
      drain++;
    end
    $display("covered %0d loads and %0d steps, %0d result beats checked, %0d touchdowns",
             sent_loads, sent_steps, beats_checked, touchdowns);
    $display("register sets from minimum to maximum, idle and stall phases, long hold-off");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("tb_lander_planar_dynamics_step_top passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_lander_planar_dynamics_step_top failed");
    end
    $finish;
  end

endmodule
